/* sv/tmprof_pkg.sv */
// Package with the shared types and constants of the trapezoidal motion profile.
package tmprof_pkg;

  localparam int unsigned NumW = 72;
  localparam int unsigned DenW = 32;

  // Configuration register indexes.
  localparam logic RegMaxVel = 1'b0;
  localparam logic RegMaxAcc = 1'b1;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_TICK  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    PH_ACCEL  = 2'd0,
    PH_CRUISE = 2'd1,
    PH_DECEL  = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd3
  } dir_e;

  typedef enum logic [4:0] {
    S_IDLE, S_S0, S_S1, S_S2, S_S3, S_S4, S_S5, S_S6, S_S7, S_S8,
    S_T1, S_T2, S_T3, S_SPH,
    S_K0, S_K1, S_K2, S_K4, S_K5, S_K6, S_K7, S_K8,
    S_C0, S_C1, S_C2,
    S_DONE
  } state_e;

  // Request from the sequencer to the iterative divide / square root unit.
  typedef struct packed {
    logic start;
    logic sqrt_op;
  } tmprof_req_t;

endpackage

/* sv/tmprof_iter.sv */
// Iterative unit: bit-serial restoring divider and bit-serial integer square root.
module tmprof_iter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tmprof_pkg::tmprof_req_t         req_i,
  input  logic [tmprof_pkg::NumW-1:0]     num_i,
  input  logic [tmprof_pkg::DenW-1:0]     den_i,
  output logic [tmprof_pkg::NumW-1:0]     res_o,
  output logic                            done_o
);
  import tmprof_pkg::*;

  logic [NumW-1:0] q_q, q_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [63:0]     r_q, r_d;
  logic [63:0]     bit_q, bit_d;
  logic [6:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            sqrt_q, sqrt_d;
  logic            done_q, done_d;

  logic [DenW:0]   rem_sh;
  logic            ge;
  logic [DenW:0]   rem_sub;
  logic [63:0]     trial;

  always_comb begin
    q_d    = q_q;
    rem_d  = rem_q;
    den_d  = den_q;
    r_d    = r_q;
    bit_d  = bit_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    sqrt_d = sqrt_q;
    done_d = 1'b0;
    rem_sh  = {rem_q, q_q[NumW-1]};
    ge      = (rem_sh >= {1'b0, den_q});
    rem_sub = rem_sh - {1'b0, den_q};
    trial   = r_q + bit_q;
    if (req_i.start) begin
      q_d    = num_i;
      rem_d  = '0;
      den_d  = den_i;
      r_d    = '0;
      bit_d  = 64'h4000_0000_0000_0000;
      cnt_d  = req_i.sqrt_op ? 7'd32 : 7'(NumW);
      busy_d = 1'b1;
      sqrt_d = req_i.sqrt_op;
    end else if (busy_q) begin
      if (sqrt_q) begin
        if (q_q[63:0] >= trial) begin
          q_d[63:0] = q_q[63:0] - trial;
          r_d       = (r_q >> 1) + bit_q;
        end else begin
          r_d = r_q >> 1;
        end
        bit_d = bit_q >> 2;
      end else begin
        rem_d = ge ? rem_sub[DenW-1:0] : rem_sh[DenW-1:0];
        q_d   = {q_q[NumW-2:0], ge};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sqrt_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
      sqrt_q <= sqrt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    rem_q <= rem_d;
    den_q <= den_d;
    r_q   <= r_d;
    bit_q <= bit_d;
  end

  assign res_o  = sqrt_q ? {8'b0, r_q} : q_q;
  assign done_o = done_q;

endmodule

/* sv/trapezoidal_motion_profile_top.sv */
// Top level of the trapezoidal motion profile setpoint generator.
// A start runs two 72-step divides for a trapezoidal move, a divide and a 32-step square
// root for a triangular one, and the divide alone when its blend time saturates.
// Tick: velocity and position divisions in accel/decel, only the position one when cruising.
// One request at a time; the next is taken in the cycle after the result register loads.
// Reset (asynchronous, active low) sets both limits to 65536 and clears the move state.
module trapezoidal_motion_profile_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [31:0] start_position_i,
  input  logic [31:0] target_position_i,
  input  logic [15:0] tick_micros_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] position_out_o,
  output logic [31:0] velocity_out_o,
  output logic [31:0] acceleration_out_o,
  output logic [1:0]  phase_o,
  output logic        move_done_o
);
  import tmprof_pkg::*;

  localparam logic [31:0] UsPerS    = 32'd1000000;
  localparam logic [31:0] TMax      = 32'hFFFF_FFFF;
  localparam logic [63:0] SqrtSat   = 64'd18446744073709000000;
  localparam logic signed [47:0] AccumLim = 48'sh7FFF_FFFF_FFFF;
  // Division by 1e6 and 2e6 is a shift followed by a division by 15625, done one
  // 16-bit digit at a time with a reciprocal multiply that is exact for every
  // partial dividend below 15625 * 2^16.
  localparam logic [31:0] CdDiv     = 32'd15625;
  localparam logic [31:0] RecipM    = 32'd1125899907;

  // Saturate a wide signed sum to the symmetric 48-bit accumulator range.
  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    logic signed [49:0] lim;
    lim = 50'(AccumLim);
    if (v > lim)       sat48 = AccumLim;
    else if (v < -lim) sat48 = -AccumLim;
    else               sat48 = v[47:0];
  endfunction

  state_e state_q, state_d;

  logic [31:0] max_vel_q, max_acc_q;
  logic signed [31:0] target_q, target_d;
  logic [31:0] dist_q, dist_d;
  logic [1:0]  dir_q, dir_d;
  logic [31:0] blend_q, blend_d, cruise_q, cruise_d, total_q, total_d;
  logic [31:0] elapsed_q, elapsed_d;
  logic signed [47:0] pos_q, pos_d, vel_q, vel_d, vnew_q, vnew_d;
  logic signed [31:0] acc_now_q, acc_now_d;
  logic [63:0] prod_q, prod_d, part_q, part_d;
  logic [51:0] tmp_q, tmp_d;
  logic        tri_q, tri_d, func_q, func_d, neg_q, neg_d;
  logic [15:0] dt_q, dt_d;
  logic [1:0]  ph_q, ph_d;
  logic [48:0] mag_q, mag_d;

  // Constant divider state: dividend digits, running remainder and quotient.
  logic [63:0] cd_num_q, cd_num_d;
  logic [13:0] cd_rem_q, cd_rem_d;
  logic [47:0] cd_quo_q, cd_quo_d;
  logic [1:0]  cd_cnt_q, cd_cnt_d;
  logic        cd_pos_q, cd_pos_d;
  logic [29:0] cd_cur;
  logic [29:0] cd_rem_full;
  logic [63:0] step_x;

  logic        out_valid_q, out_valid_d;
  logic [31:0] out_pos_q, out_pos_d, out_vel_q, out_vel_d, out_acc_q, out_acc_d;
  logic [1:0]  out_ph_q, out_ph_d;
  logic        out_done_q, out_done_d;

  // Shared multiplier and iterative unit hookup.
  logic [31:0] mul_a, mul_b;
  tmprof_req_t req;
  logic [NumW-1:0] div_num, div_res;
  logic [DenW-1:0] div_den;
  logic        div_done;

  // Effective limits: zero is taken as one.
  logic [31:0] lim_v, lim_a;
  logic [30:0] am;
  logic signed [47:0] cruise_vel;
  logic [1:0]  ph_now;
  logic [32:0] bc_sum;
  logic        spos, sneg;
  logic signed [32:0] delta;
  logic [32:0] el_sum;
  logic signed [49:0] vsum, psum;
  logic signed [48:0] vv_sum;
  logic [52:0] cr_sub;
  logic [53:0] cr_add;
  logic [31:0] tb;

  assign lim_v = (max_vel_q == '0) ? 32'd1 : max_vel_q;
  assign lim_a = (max_acc_q == '0) ? 32'd1 : max_acc_q;
  assign am    = lim_a[31] ? 31'h7FFF_FFFF : lim_a[30:0];
  assign cruise_vel = lim_v[31] ? AccumLim : $signed({1'b0, lim_v[30:0], 16'b0});

  // Partial dividend of the current digit: remainder so far and the next 16 bits.
  assign cd_cur = {cd_rem_q, cd_num_q[63:48]};

  // Phase of the current move clock.
  assign bc_sum = {1'b0, blend_q} + {1'b0, cruise_q};
  always_comb begin
    priority if (elapsed_q < blend_q)           ph_now = PH_ACCEL;
    else if ({1'b0, elapsed_q} < bc_sum)        ph_now = PH_CRUISE;
    else if (elapsed_q <= total_q)              ph_now = PH_DECEL;
    else                                        ph_now = PH_DONE;
  end

  // Sign of the acceleration in the current phase.
  assign spos = (ph_q == PH_ACCEL && dir_q == DIR_UP) || (ph_q == PH_DECEL && dir_q == DIR_DOWN);
  assign sneg = (ph_q == PH_ACCEL && dir_q == DIR_DOWN) || (ph_q == PH_DECEL && dir_q == DIR_UP);

  assign in_ready_o = (state_q == S_IDLE);

  // Multiplier operand selection by sequencer step; product is registered.
  always_comb begin
    unique case (state_q)
      S_S0:    begin mul_a = dist_q;               mul_b = lim_a;           end
      S_S1:    begin mul_a = lim_v;                mul_b = lim_v;           end
      S_S2:    begin mul_a = dist_q;               mul_b = UsPerS;          end
      S_S3:    begin mul_a = lim_v;                mul_b = UsPerS;          end
      S_S4:    begin mul_a = tmp_q[31:0];          mul_b = UsPerS;          end
      S_S5:    begin mul_a = {12'b0, tmp_q[51:32]}; mul_b = UsPerS;         end
      S_K0:    begin mul_a = {1'b0, am};           mul_b = {16'b0, dt_q};   end
      S_K5:    begin mul_a = mag_q[31:0];          mul_b = {16'b0, dt_q};   end
      S_K6:    begin mul_a = {15'b0, mag_q[48:32]}; mul_b = {16'b0, dt_q};  end
      S_C0:    begin mul_a = {2'b0, cd_cur};        mul_b = RecipM;         end
      S_C1:    begin mul_a = {16'b0, prod_q[59:44]}; mul_b = CdDiv;         end
      default: begin mul_a = '0;                   mul_b = '0;              end
    endcase
  end
  assign prod_d = mul_a * mul_b;

  always_comb begin
    state_d     = state_q;
    target_d    = target_q;
    dist_d      = dist_q;
    dir_d       = dir_q;
    blend_d     = blend_q;
    cruise_d    = cruise_q;
    total_d     = total_q;
    elapsed_d   = elapsed_q;
    pos_d       = pos_q;
    vel_d       = vel_q;
    vnew_d      = vnew_q;
    acc_now_d   = acc_now_q;
    part_d      = part_q;
    tmp_d       = tmp_q;
    tri_d       = tri_q;
    func_d      = func_q;
    neg_d       = neg_q;
    dt_d        = dt_q;
    ph_d        = ph_q;
    mag_d       = mag_q;
    cd_num_d    = cd_num_q;
    cd_rem_d    = cd_rem_q;
    cd_quo_d    = cd_quo_q;
    cd_cnt_d    = cd_cnt_q;
    cd_pos_d    = cd_pos_q;
    out_valid_d = out_valid_q;
    out_pos_d   = out_pos_q;
    out_vel_d   = out_vel_q;
    out_acc_d   = out_acc_q;
    out_ph_d    = out_ph_q;
    out_done_d  = out_done_q;
    req         = '0;
    div_num     = '0;
    div_den     = '0;
    delta  = $signed({target_position_i[31], target_position_i})
           - $signed({start_position_i[31], start_position_i});
    el_sum = {1'b0, elapsed_q} + {17'b0, tick_micros_i};
    vsum   = '0;
    psum   = '0;
    vv_sum = '0;
    cr_sub = '0;
    cr_add = '0;
    tb     = div_res[31:0];
    step_x      = part_q + {prod_q[31:0], 32'b0};
    cd_rem_full = cd_cur - prod_q[29:0];

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          func_d = func_i;
          if (func_i == FUNC_START) begin
            target_d  = target_position_i;
            dist_d    = delta[32] ? 32'(-delta) : delta[31:0];
            dir_d     = (delta == '0) ? DIR_NONE : (delta[32] ? DIR_DOWN : DIR_UP);
            pos_d     = $signed({start_position_i, 16'b0});
            vel_d     = '0;
            acc_now_d = '0;
            elapsed_d = '0;
            state_d   = S_S0;
          end else begin
            dt_d      = tick_micros_i;
            elapsed_d = el_sum[32] ? TMax : el_sum[31:0];
            state_d   = S_K0;
          end
        end
      end
      // Start: distance times acceleration against velocity squared.
      S_S0: state_d = S_S1;
      S_S1: begin
        tmp_d   = prod_q[51:0];
        part_d  = prod_q;
        state_d = S_S2;
      end
      S_S2: begin
        tri_d   = (part_q <= prod_q);
        state_d = S_S3;
      end
      S_S3: begin
        tmp_d   = prod_q[51:0];
        state_d = tri_q ? S_S4 : S_T1;
      end
      // Triangular move: blend time is the root of distance * 1e12 / accel.
      S_S4: state_d = S_S5;
      S_S5: begin
        part_d  = prod_q;
        state_d = S_S6;
      end
      S_S6: begin
        req.start = 1'b1;
        div_num   = {8'b0, part_q} + {prod_q[39:0], 32'b0};
        div_den   = lim_a;
        state_d   = S_S7;
      end
      S_S7: begin
        if (div_done) begin
          if (div_res[71:64] != '0 || div_res[63:0] >= SqrtSat) begin
            blend_d  = TMax;
            cruise_d = '0;
            total_d  = TMax;
            state_d  = S_SPH;
          end else begin
            req.start   = 1'b1;
            req.sqrt_op = 1'b1;
            div_num     = {8'b0, div_res[63:0]};
            state_d     = S_S8;
          end
        end
      end
      S_S8: begin
        if (div_done) begin
          blend_d  = tb;
          cruise_d = '0;
          total_d  = tb[31] ? TMax : {tb[30:0], 1'b0};
          state_d  = S_SPH;
        end
      end
      // Trapezoidal move: blend = V/A, cruise and total from D/V.
      S_T1: begin
        req.start = 1'b1;
        div_num   = {8'b0, prod_q};
        div_den   = lim_a;
        state_d   = S_T2;
      end
      S_T2: begin
        if (div_done) begin
          blend_d   = (div_res[71:32] != '0) ? TMax : div_res[31:0];
          req.start = 1'b1;
          div_num   = {20'b0, tmp_q};
          div_den   = lim_v;
          state_d   = S_T3;
        end
      end
      S_T3: begin
        if (div_done) begin
          cr_sub   = div_res[52:0] - {21'b0, blend_q};
          cr_add   = {1'b0, div_res[52:0]} + {22'b0, blend_q};
          cruise_d = (cr_sub[52:32] != '0) ? TMax : cr_sub[31:0];
          total_d  = (cr_add[53:32] != '0) ? TMax : cr_add[31:0];
          state_d  = S_SPH;
        end
      end
      S_SPH: begin
        ph_d    = ph_now;
        state_d = S_DONE;
      end
      // Tick: pick the phase, then update velocity and position.
      S_K0: begin
        ph_d = ph_now;
        unique case (ph_now)
          PH_DONE: begin
            pos_d     = $signed({target_q, 16'b0});
            vel_d     = '0;
            acc_now_d = '0;
            state_d   = S_DONE;
          end
          PH_CRUISE: begin
            acc_now_d = '0;
            if (dir_q == DIR_UP)        vnew_d = cruise_vel;
            else if (dir_q == DIR_DOWN) vnew_d = -cruise_vel;
            else                        vnew_d = '0;
            state_d = S_K4;
          end
          default: begin
            state_d = S_K1;
          end
        endcase
      end
      // Velocity step: accel * dt * 2^16 / 1e6, that is (accel * dt * 2^10) / 15625.
      S_K1: begin
        if (spos)      acc_now_d = $signed({1'b0, am});
        else if (sneg) acc_now_d = -$signed({1'b0, am});
        else           acc_now_d = '0;
        cd_num_d = {7'b0, prod_q[46:0], 10'b0};
        cd_rem_d = '0;
        cd_cnt_d = '0;
        cd_pos_d = 1'b0;
        state_d  = S_C0;
      end
      // Constant division, one 16-bit digit per pass, most significant first.
      S_C0: state_d = S_C1;
      S_C1: begin
        cd_quo_d = {cd_quo_q[31:0], prod_q[59:44]};
        state_d  = S_C2;
      end
      S_C2: begin
        cd_rem_d = cd_rem_full[13:0];
        cd_num_d = {cd_num_q[47:0], 16'b0};
        cd_cnt_d = cd_cnt_q + 2'd1;
        if (cd_cnt_q == 2'd3) state_d = cd_pos_q ? S_K8 : S_K2;
        else                  state_d = S_C0;
      end
      S_K2: begin
        if (spos)      vsum = 50'(vel_q) + $signed({2'b0, cd_quo_q});
        else if (sneg) vsum = 50'(vel_q) - $signed({2'b0, cd_quo_q});
        else           vsum = 50'(vel_q);
        vnew_d  = sat48(vsum);
        state_d = S_K4;
      end
      S_K4: begin
        vv_sum  = 49'(vel_q) + 49'(vnew_q);
        neg_d   = vv_sum[48];
        mag_d   = vv_sum[48] ? 49'(-vv_sum) : vv_sum;
        state_d = S_K5;
      end
      S_K5: state_d = S_K6;
      S_K6: begin
        part_d  = prod_q;
        state_d = S_K7;
      end
      // Position step: |v_old + v_new| * dt / 2e6, that is ((...) >> 7) / 15625.
      S_K7: begin
        cd_num_d = {7'b0, step_x[63:7]};
        cd_rem_d = '0;
        cd_cnt_d = '0;
        cd_pos_d = 1'b1;
        state_d  = S_C0;
      end
      S_K8: begin
        if (neg_q) psum = 50'(pos_q) - $signed({2'b0, cd_quo_q});
        else       psum = 50'(pos_q) + $signed({2'b0, cd_quo_q});
        pos_d   = sat48(psum);
        vel_d   = vnew_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_pos_d   = pos_q[47:16];
          out_vel_d   = vel_q[47:16];
          out_acc_d   = acc_now_q;
          out_ph_d    = ph_q;
          out_done_d  = (func_q == FUNC_TICK) && (ph_q == PH_DONE);
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  tmprof_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .num_i  (div_num),
    .den_i  (div_den),
    .res_o  (div_res),
    .done_o (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      max_vel_q   <= 32'd65536;
      max_acc_q   <= 32'd65536;
      target_q    <= '0;
      dist_q      <= '0;
      dir_q       <= DIR_NONE;
      blend_q     <= '0;
      cruise_q    <= '0;
      total_q     <= '0;
      elapsed_q   <= '0;
      pos_q       <= '0;
      vel_q       <= '0;
      acc_now_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      target_q    <= target_d;
      dist_q      <= dist_d;
      dir_q       <= dir_d;
      blend_q     <= blend_d;
      cruise_q    <= cruise_d;
      total_q     <= total_d;
      elapsed_q   <= elapsed_d;
      pos_q       <= pos_d;
      vel_q       <= vel_d;
      acc_now_q   <= acc_now_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == RegMaxAcc) max_acc_q <= cfg_wdata_i;
        else                        max_vel_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= prod_d;
    part_q     <= part_d;
    tmp_q      <= tmp_d;
    tri_q      <= tri_d;
    func_q     <= func_d;
    neg_q      <= neg_d;
    dt_q       <= dt_d;
    ph_q       <= ph_d;
    mag_q      <= mag_d;
    vnew_q     <= vnew_d;
    cd_num_q   <= cd_num_d;
    cd_rem_q   <= cd_rem_d;
    cd_quo_q   <= cd_quo_d;
    cd_cnt_q   <= cd_cnt_d;
    cd_pos_q   <= cd_pos_d;
    out_pos_q  <= out_pos_d;
    out_vel_q  <= out_vel_d;
    out_acc_q  <= out_acc_d;
    out_ph_q   <= out_ph_d;
    out_done_q <= out_done_d;
  end

  assign out_valid_o        = out_valid_q;
  assign position_out_o     = out_pos_q;
  assign velocity_out_o     = out_vel_q;
  assign acceleration_out_o = out_acc_q;
  assign phase_o            = out_ph_q;
  assign move_done_o        = out_done_q;

endmodule
